/* rtl/sorted_list_intersection_assert.svh */
// ---------------------------------------------------------------------------
// Sorted list intersection assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INTERSECTION_ASSERT_SVH
`define SORTED_LIST_INTERSECTION_ASSERT_SVH

// The property must hold at every rising clock edge outside reset.
`define SLI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define SLI_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/sli_pkg.sv */
// ---------------------------------------------------------------------------
// Sorted list intersection package
// Request codes, sequencer states and default sizes.
// ---------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 64;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned REQ_W          = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND_A = 2'd0,
    REQ_APPEND_B = 2'd1,
    REQ_START    = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

endpackage

/* rtl/sli_ram.sv */
// ---------------------------------------------------------------------------
// Sorted list intersection RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module sli_ram #(
  parameter int unsigned WIDTH = sli_pkg::VALUE_W,
  parameter int unsigned DEPTH = sli_pkg::LIST_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/sorted_list_intersection.sv */
// ---------------------------------------------------------------------------
// Sorted list intersection
// Loads two ascending lists and streams out the values common to both.
// ---------------------------------------------------------------------------
// A word is accepted when start is high and busy is low. Request code
// append A or append B stores in_item_value at the end of that list; a
// word for a full list is dropped. Request code start runs a two-pointer
// merge walk over both lists and holds busy high meanwhile. One compare
// of the two list heads is made per cycle, fed by the registered read
// ports of the two list RAMs. Each common value appears on the out_ ports
// for one cycle with out_valid high; the final one carries out_last_match
// and shows in the same cycle in which busy falls. A run without a match
// gives one word with both out_last_match and out_empty_result high and a
// zero value. The receiver cannot stall, so results are never held back.
// Both list lengths clear at the end of a run. Reset empties both lists
// and returns the block to idle.
// ---------------------------------------------------------------------------
module sorted_list_intersection #(
  parameter int unsigned LIST_DEPTH = sli_pkg::LIST_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [sli_pkg::REQ_W-1:0]    in_req_type,
  input  logic signed [sli_pkg::VALUE_W-1:0] in_item_value,
  output logic                         out_valid,
  output logic signed [sli_pkg::VALUE_W-1:0] out_match_value,
  output logic                         out_last_match,
  output logic                         out_empty_result
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  sli_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic signed [sli_pkg::VALUE_W-1:0] pend_val_r, pend_val_nxt;
  logic          ovld_nxt, olast_nxt, oempty_nxt;
  logic signed [sli_pkg::VALUE_W-1:0] oval_nxt;

  logic          accept;
  logic          we_a, we_b;
  logic signed [sli_pkg::VALUE_W-1:0] head_a, head_b;
  logic          walk_on;

  assign busy   = (state_r == sli_pkg::ST_WALK);
  assign accept = start && !busy;
  assign we_a   = accept && (in_req_type == sli_pkg::REQ_APPEND_A) && (cnt_a_r < DEPTH_C);
  assign we_b   = accept && (in_req_type == sli_pkg::REQ_APPEND_B) && (cnt_b_r < DEPTH_C);
  assign walk_on = (ia_r < cnt_a_r) && (ib_r < cnt_b_r);

  sli_ram #(
    .WIDTH (sli_pkg::VALUE_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (in_item_value),
    .raddr (ia_nxt[AW-1:0]),
    .rdata (head_a)
  );

  sli_ram #(
    .WIDTH (sli_pkg::VALUE_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (in_item_value),
    .raddr (ib_nxt[AW-1:0]),
    .rdata (head_b)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    ia_nxt       = ia_r;
    ib_nxt       = ib_r;
    pend_vld_nxt = pend_vld_r;
    pend_val_nxt = pend_val_r;
    ovld_nxt     = 1'b0;
    oval_nxt     = pend_val_r;
    olast_nxt    = 1'b0;
    oempty_nxt   = 1'b0;
    unique case (state_r)
      sli_pkg::ST_IDLE: begin
        if (we_a) begin
          cnt_a_nxt = cnt_a_r + CW'(1);
        end
        if (we_b) begin
          cnt_b_nxt = cnt_b_r + CW'(1);
        end
        if (accept && (in_req_type == sli_pkg::REQ_START)) begin
          pend_vld_nxt = 1'b0;
          state_nxt    = sli_pkg::ST_WALK;
        end
      end
      sli_pkg::ST_WALK: begin
        if (walk_on) begin
          priority if (head_a < head_b) begin
            ia_nxt = ia_r + CW'(1);
          end else if (head_b < head_a) begin
            ib_nxt = ib_r + CW'(1);
          end else begin
            ia_nxt       = ia_r + CW'(1);
            ib_nxt       = ib_r + CW'(1);
            ovld_nxt     = pend_vld_r;
            pend_vld_nxt = 1'b1;
            pend_val_nxt = head_a;
          end
        end else begin
          ovld_nxt     = 1'b1;
          olast_nxt    = 1'b1;
          oempty_nxt   = !pend_vld_r;
          oval_nxt     = pend_vld_r ? pend_val_r : '0;
          pend_vld_nxt = 1'b0;
          ia_nxt       = '0;
          ib_nxt       = '0;
          cnt_a_nxt    = '0;
          cnt_b_nxt    = '0;
          state_nxt    = sli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sli_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sli_pkg::ST_IDLE;
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      ia_r       <= '0;
      ib_r       <= '0;
      pend_vld_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_a_r    <= cnt_a_nxt;
      cnt_b_r    <= cnt_b_nxt;
      ia_r       <= ia_nxt;
      ib_r       <= ib_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_valid  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_val_r       <= pend_val_nxt;
    out_match_value  <= oval_nxt;
    out_last_match   <= olast_nxt;
    out_empty_result <= oempty_nxt;
  end

endmodule

/* rtl/sli_checker.sv */
// ---------------------------------------------------------------------------
// Sorted list intersection checker
// Port-level assertions on the run sequencing and result flags.
// ---------------------------------------------------------------------------
`include "sorted_list_intersection_assert.svh"

module sli_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [sli_pkg::REQ_W-1:0]           in_req_type,
  input logic                                out_valid,
  input logic signed [sli_pkg::VALUE_W-1:0]  out_match_value,
  input logic                                out_last_match,
  input logic                                out_empty_result
);

  logic run_req;
  logic last_word;
  logic empty_word;
  logic zero_last;

  assign run_req    = start && !busy && (in_req_type == sli_pkg::REQ_START);
  assign last_word  = out_valid && out_last_match;
  assign empty_word = out_valid && out_empty_result;
  assign zero_last  = out_last_match && (out_match_value == '0);

  `SLI_ASSERT(a_run_starts, clk, rst_n, run_req |=> busy, "start word did not begin a run")
  `SLI_ASSERT(a_result_in_run, clk, rst_n, out_valid |-> $past(busy), "result word outside a run")
  `SLI_ASSERT(a_last_ends_run, clk, rst_n, last_word |-> !busy, "run busy after its last word")
  `SLI_ASSERT(a_empty_is_last, clk, rst_n, empty_word |-> zero_last, "empty word is not zero and final")

endmodule

bind sorted_list_intersection sli_checker u_sli_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_req_type      (in_req_type),
  .out_valid        (out_valid),
  .out_match_value  (out_match_value),
  .out_last_match   (out_last_match),
  .out_empty_result (out_empty_result)
);

/* sim/tb_sorted_list_intersection.sv */
// ---------------------------------------------------------------------------
// Sorted list intersection testbench
// Loads list A and list B through the command port, starts merge walks and
// checks every result word against an in-bench prediction of the walk.
// Directed tests cover empty lists, signed extremes, the unused request code,
// repeated and unsorted values and full lists; random runs follow.
// ---------------------------------------------------------------------------
module tb_sorted_list_intersection;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = sli_pkg::LIST_DEPTH_DEF;
  localparam logic [sli_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned WALK_CYCLES  = 2 * DEPTH + 4;
  localparam int unsigned TARGET_WORDS = 430;

  typedef logic signed [sli_pkg::VALUE_W-1:0] value_t;

  typedef struct {
    value_t value;
    logic   last;
    logic   empty;
  } match_word_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [sli_pkg::REQ_W-1:0] in_req_type;
  value_t                    in_item_value;
  logic                      out_valid;
  value_t                    out_match_value;
  logic                      out_last_match;
  logic                      out_empty_result;

  value_t      list_a [DEPTH];
  value_t      list_b [DEPTH];
  int unsigned len_a = 0;
  int unsigned len_b = 0;
  match_word_t pending_matches [$];
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned max_gap = 16;

  sorted_list_intersection uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_match_value  (out_match_value),
    .out_last_match   (out_last_match),
    .out_empty_result (out_empty_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void intersect_lists();
    int unsigned ia;
    int unsigned ib;
    value_t      found [$];
    match_word_t word;
    ia = 0;
    ib = 0;
    while (ia < len_a && ib < len_b) begin
      if (list_a[ia] < list_b[ib]) begin
        ia++;
      end else if (list_b[ib] < list_a[ia]) begin
        ib++;
      end else begin
        found.push_back(list_a[ia]);
        ia++;
        ib++;
      end
    end
    if (found.size() == 0) begin
      word.value = '0;
      word.last  = 1'b1;
      word.empty = 1'b1;
      pending_matches.push_back(word);
    end
    for (int i = 0; i < found.size(); i++) begin
      word.value = found[i];
      word.last  = (i == found.size() - 1);
      word.empty = 1'b0;
      pending_matches.push_back(word);
    end
    len_a = 0;
    len_b = 0;
  endfunction

  always @(posedge clk) begin : check_results
    match_word_t exp_word;
    if (rst_n && out_valid) begin
      if (pending_matches.size() == 0) begin
        $error("result word with none expected: match_value %0d", out_match_value);
        mismatches++;
      end else begin
        exp_word = pending_matches.pop_front();
        if (out_match_value !== exp_word.value) begin
          $error("match_value: expected %0d, actual %0d", exp_word.value, out_match_value);
          mismatches++;
        end
        if (out_last_match !== exp_word.last) begin
          $error("last_match: expected %0b, actual %0b", exp_word.last, out_last_match);
          mismatches++;
        end
        if (out_empty_result !== exp_word.empty) begin
          $error("empty_result: expected %0b, actual %0b", exp_word.empty, out_empty_result);
          mismatches++;
        end
      end
    end
  end

  task automatic send_word(input logic [sli_pkg::REQ_W-1:0] req, input value_t value);
    int unsigned gap;
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_item_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (req)
      sli_pkg::REQ_APPEND_A: begin
        if (len_a < DEPTH) begin
          list_a[len_a] = value;
          len_a++;
          words_sent++;
        end
      end
      sli_pkg::REQ_APPEND_B: begin
        if (len_b < DEPTH) begin
          list_b[len_b] = value;
          len_b++;
          words_sent++;
        end
      end
      sli_pkg::REQ_START: begin
        intersect_lists();
        words_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_lists();
    send_word(sli_pkg::REQ_START, 32'sd0);
  endtask

  task automatic test_signed_extremes();
    send_word(sli_pkg::REQ_APPEND_A, 32'sh8000_0000);
    send_word(sli_pkg::REQ_APPEND_B, 32'sh8000_0000);
    send_word(sli_pkg::REQ_APPEND_A, -32'sd1);
    send_word(sli_pkg::REQ_APPEND_A, 32'sd0);
    send_word(sli_pkg::REQ_APPEND_B, 32'sd0);
    send_word(sli_pkg::REQ_APPEND_B, 32'sd1);
    send_word(sli_pkg::REQ_APPEND_A, 32'sh7fff_ffff);
    send_word(sli_pkg::REQ_APPEND_B, 32'sh7fff_ffff);
    send_word(sli_pkg::REQ_START, -32'sd1);
  endtask

  task automatic test_unused_request();
    send_word(sli_pkg::REQ_APPEND_A, 32'sd5);
    send_word(REQ_UNUSED, 32'sd5);
    send_word(sli_pkg::REQ_APPEND_B, 32'sd5);
    send_word(sli_pkg::REQ_START, 32'sd0);
  endtask

  task automatic test_one_list_empty();
    send_word(sli_pkg::REQ_APPEND_A, 32'sd7);
    send_word(sli_pkg::REQ_START, 32'sd7);
    send_word(sli_pkg::REQ_APPEND_B, -32'sd7);
    send_word(sli_pkg::REQ_START, 32'sd0);
  endtask

  task automatic test_repeated_unsorted();
    send_word(sli_pkg::REQ_APPEND_A, 32'sd3);
    send_word(sli_pkg::REQ_APPEND_A, 32'sd3);
    send_word(sli_pkg::REQ_APPEND_A, 32'sd1);
    send_word(sli_pkg::REQ_APPEND_B, 32'sd3);
    send_word(sli_pkg::REQ_APPEND_B, 32'sd3);
    send_word(sli_pkg::REQ_APPEND_B, 32'sd3);
    send_word(sli_pkg::REQ_START, 32'sd0);
  endtask

  task automatic test_full_lists();
    max_gap = 2;
    for (int i = 0; i < DEPTH + 2; i++) begin
      send_word(sli_pkg::REQ_APPEND_A, value_t'(i - 32));
      send_word(sli_pkg::REQ_APPEND_B, value_t'(i - 32));
    end
    send_word(sli_pkg::REQ_START, 32'sd0);
    hold_until_drained();
  endtask

  function automatic int unsigned draw_length();
    case ($urandom_range(0, 15))
      0:       return $urandom_range(DEPTH - 4, DEPTH + 3);
      1:       return 0;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic random_run();
    value_t      run_a [$];
    value_t      run_b [$];
    value_t      next_a;
    value_t      next_b;
    int unsigned na;
    int unsigned nb;
    logic        scrambled;
    max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 16;
    na        = draw_length();
    nb        = draw_length();
    scrambled = ($urandom_range(0, 7) == 0);
    next_a    = $urandom;
    next_b    = next_a + value_t'($urandom_range(0, 4));
    for (int i = 0; i < na; i++) begin
      next_a = next_a + value_t'($urandom_range(0, 3));
      run_a.push_back(scrambled ? value_t'($urandom) : next_a);
    end
    for (int i = 0; i < nb; i++) begin
      next_b = next_b + value_t'($urandom_range(0, 3));
      run_b.push_back(scrambled ? value_t'($urandom) : next_b);
    end
    while (run_a.size() != 0 || run_b.size() != 0) begin
      if ($urandom_range(0, 19) == 0)
        send_word(REQ_UNUSED, value_t'($urandom));
      else if (run_b.size() == 0 || (run_a.size() != 0 && $urandom_range(0, 1) == 0))
        send_word(sli_pkg::REQ_APPEND_A, run_a.pop_front());
      else
        send_word(sli_pkg::REQ_APPEND_B, run_b.pop_front());
    end
    send_word(sli_pkg::REQ_START, value_t'($urandom));
    if ($urandom_range(0, 5) == 0)
      hold_until_drained();
  endtask

  task automatic test_random_runs();
    while (words_sent < TARGET_WORDS) random_run();
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = sli_pkg::REQ_APPEND_A;
    in_item_value = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_lists();
    test_signed_extremes();
    test_unused_request();
    hold_until_drained();
    test_one_list_empty();
    test_repeated_unsorted();
    test_full_lists();
    test_random_runs();

    hold_until_drained();
    repeat (WALK_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
